// ===== rtl/core/i2c_master_bit_sequencer_macros.svh =====
// Assertion macros shared by the I2C master bit sequencer RTL.
// Each macro expects clk and arst_n to be visible in the module that uses it.
`ifndef I2C_MASTER_BIT_SEQUENCER_MACROS_SVH
`define I2C_MASTER_BIT_SEQUENCER_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define I2CBS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked while out of reset.
`define I2CBS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/i2cbs_pkg.sv =====
// Types and constants for the I2C master bit sequencer.
// Used by i2cbs_seq and the top level i2c_master_bit_sequencer; no dependencies.
package i2cbs_pkg;

	localparam int BYTE_BITS = 8;

	localparam logic [2:0] KIND_TICK      = 3'd0;
	localparam logic [2:0] KIND_START     = 3'd1;
	localparam logic [2:0] KIND_STOP      = 3'd2;
	localparam logic [2:0] KIND_WRITE     = 3'd3;
	localparam logic [2:0] KIND_READ_ACK  = 3'd4;
	localparam logic [2:0] KIND_READ_NACK = 3'd5;

	localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

	typedef enum logic [4:0] {
		PH_IDLE,
		PH_START2,
		PH_START3,
		PH_START4,
		PH_STOP2,
		PH_STOP3,
		PH_STOP4,
		PH_WBIT_A,
		PH_WBIT_B,
		PH_WBIT_C,
		PH_WREL,
		PH_WPOLL,
		PH_ESTOP2,
		PH_ESTOP3,
		PH_ESTOP4,
		PH_RBIT_A,
		PH_RBIT_B,
		PH_RACK_A,
		PH_RACK_B,
		PH_RACK_C
	} phase_t;

	// One input word.
	typedef struct packed {
		logic [2:0]           kind;
		logic [BYTE_BITS-1:0] write_byte;
		logic                 sda_in;
	} tick_t;

	// One result word.
	typedef struct packed {
		logic [BYTE_BITS-1:0] read_data;
		logic                 ack_error;
		logic                 done_res;
		logic                 busy_res;
		logic                 sda_drive;
		logic                 sda_out;
		logic                 scl;
	} res_t;

endpackage

// ===== rtl/core/i2c_master_bit_sequencer.sv =====
// I2C master bit sequencer, top level: stream ports, timeout register and
// output register. Depends on i2cbs_pkg, i2cbs_seq and the macros header.
//
// Every input word is one bus tick and yields exactly one result word in the
// cycle after it is taken. The sequencer state and the result register update
// together on acceptance, and s_tready stays high while the result register is
// empty or being drained, so the rate is one word per clock while m_tready
// holds. A command in s_tuser starts a line sequence only when the sequencer
// is idle. The acknowledge timeout is written through cfg_wr_en / cfg_wr_data
// and should change only while idle.
`include "i2c_master_bit_sequencer_macros.svh"

module i2c_master_bit_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // write_byte[7:0], sda_in[8], zero[15:9]
	input  logic [2:0]  s_tuser,   // kind[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // scl[0], sda_out[1], sda_drive[2], busy_res[3],
	                               // done_res[4], ack_error[5], read_data[13:6],
	                               // zero[15:14]
);

	logic [7:0]        timeout_q;
	logic              accept;
	i2cbs_pkg::tick_t  tick;
	i2cbs_pkg::res_t   res;
	i2cbs_pkg::res_t   res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= i2cbs_pkg::ACK_TIMEOUT_RESET;
		end else if (cfg_wr_en) begin
			timeout_q <= cfg_wr_data;
		end
	end

	assign s_tready = !m_tvalid || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign tick.kind       = s_tuser;
	assign tick.write_byte = s_tdata[7:0];
	assign tick.sda_in     = s_tdata[8];

	i2cbs_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (accept),
		.tick        (tick),
		.ack_timeout (timeout_q),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (s_tready) begin
			m_tvalid <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	assign m_tdata = {2'b00, res_q.read_data, res_q.ack_error, res_q.done_res,
		res_q.busy_res, res_q.sda_drive, res_q.sda_out, res_q.scl};

	`I2CBS_ASSERT_NEXT(a_word_out, accept, m_tvalid, "accepted word produced no result")
	`I2CBS_ASSERT_NOW(a_backpressure, m_tvalid && !m_tready, !s_tready, "took a word while stalled")
	`I2CBS_ASSERT_NOW(a_done_idle, m_tvalid && res_q.done_res, !res_q.busy_res, "done while busy")
	`I2CBS_ASSERT_NOW(a_err_done, m_tvalid && res_q.ack_error, res_q.done_res, "error without done")

endmodule

// ===== rtl/core/i2cbs_seq.sv =====
// Bit-level sequencer: phase register, shift register, bit and poll counters, and the
// next-state logic for one tick. Depends on i2cbs_pkg.
module i2cbs_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  i2cbs_pkg::tick_t   tick,
	input  logic [7:0]         ack_timeout,
	output i2cbs_pkg::res_t    res
);

	i2cbs_pkg::phase_t                   phase_q, phase_d;
	logic [3:0]                          bit_count_q, bit_count_d;
	logic [i2cbs_pkg::BYTE_BITS-1:0]     shift_q, shift_d;
	logic [7:0]                          poll_q, poll_d;
	logic                                scl_q, scl_d;
	logic                                sda_q, sda_d;
	logic                                drive_q, drive_d;
	logic                                send_ack_q, send_ack_d;
	logic [i2cbs_pkg::BYTE_BITS-1:0]     rx_byte_q, rx_byte_d;
	logic [8:0]                          poll_inc;
	logic                                done, err;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= i2cbs_pkg::PH_IDLE;
			bit_count_q <= '0;
			shift_q     <= '0;
			poll_q      <= '0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			drive_q     <= 1'b0;
			send_ack_q  <= 1'b0;
			rx_byte_q   <= '0;
		end else if (advance) begin
			phase_q     <= phase_d;
			bit_count_q <= bit_count_d;
			shift_q     <= shift_d;
			poll_q      <= poll_d;
			scl_q       <= scl_d;
			sda_q       <= sda_d;
			drive_q     <= drive_d;
			send_ack_q  <= send_ack_d;
			rx_byte_q   <= rx_byte_d;
		end
	end

	assign poll_inc = {1'b0, poll_q} + 9'd1;

	always_comb begin
		phase_d     = phase_q;
		bit_count_d = bit_count_q;
		shift_d     = shift_q;
		poll_d      = poll_q;
		scl_d       = scl_q;
		sda_d       = sda_q;
		drive_d     = drive_q;
		send_ack_d  = send_ack_q;
		rx_byte_d   = rx_byte_q;
		done        = 1'b0;
		err         = 1'b0;
		case (phase_q)
			i2cbs_pkg::PH_IDLE: begin
				case (tick.kind)
					i2cbs_pkg::KIND_START: begin
						drive_d = 1'b1;
						sda_d   = 1'b1;
						phase_d = i2cbs_pkg::PH_START2;
					end
					i2cbs_pkg::KIND_STOP: begin
						drive_d = 1'b1;
						scl_d   = 1'b0;
						phase_d = i2cbs_pkg::PH_STOP2;
					end
					i2cbs_pkg::KIND_WRITE: begin
						// The first data bit goes out on the command tick itself.
						shift_d     = tick.write_byte;
						bit_count_d = '0;
						drive_d     = 1'b1;
						scl_d       = 1'b0;
						sda_d       = tick.write_byte[i2cbs_pkg::BYTE_BITS-1];
						phase_d     = i2cbs_pkg::PH_WBIT_B;
					end
					i2cbs_pkg::KIND_READ_ACK, i2cbs_pkg::KIND_READ_NACK: begin
						send_ack_d  = (tick.kind == i2cbs_pkg::KIND_READ_ACK);
						shift_d     = '0;
						bit_count_d = '0;
						drive_d     = 1'b0;
						scl_d       = 1'b0;
						phase_d     = i2cbs_pkg::PH_RBIT_A;
					end
					default: begin
					end
				endcase
			end
			i2cbs_pkg::PH_START2: begin
				scl_d   = 1'b1;
				phase_d = i2cbs_pkg::PH_START3;
			end
			i2cbs_pkg::PH_START3: begin
				sda_d   = 1'b0;
				phase_d = i2cbs_pkg::PH_START4;
			end
			i2cbs_pkg::PH_START4: begin
				scl_d   = 1'b0;
				phase_d = i2cbs_pkg::PH_IDLE;
				done    = 1'b1;
			end
			i2cbs_pkg::PH_STOP2: begin
				sda_d   = 1'b0;
				phase_d = i2cbs_pkg::PH_STOP3;
			end
			i2cbs_pkg::PH_STOP3: begin
				scl_d   = 1'b1;
				phase_d = i2cbs_pkg::PH_STOP4;
			end
			i2cbs_pkg::PH_STOP4: begin
				sda_d   = 1'b1;
				phase_d = i2cbs_pkg::PH_IDLE;
				done    = 1'b1;
			end
			i2cbs_pkg::PH_WBIT_A: begin
				scl_d   = 1'b0;
				sda_d   = shift_q[i2cbs_pkg::BYTE_BITS-1];
				phase_d = i2cbs_pkg::PH_WBIT_B;
			end
			i2cbs_pkg::PH_WBIT_B: begin
				scl_d   = 1'b1;
				phase_d = i2cbs_pkg::PH_WBIT_C;
			end
			i2cbs_pkg::PH_WBIT_C: begin
				scl_d       = 1'b0;
				shift_d     = {shift_q[i2cbs_pkg::BYTE_BITS-2:0], 1'b0};
				bit_count_d = bit_count_q + 4'd1;
				phase_d     = (bit_count_d >= 4'(i2cbs_pkg::BYTE_BITS)) ?
					i2cbs_pkg::PH_WREL : i2cbs_pkg::PH_WBIT_A;
			end
			i2cbs_pkg::PH_WREL: begin
				drive_d = 1'b0;
				scl_d   = 1'b1;
				poll_d  = '0;
				phase_d = i2cbs_pkg::PH_WPOLL;
			end
			i2cbs_pkg::PH_WPOLL: begin
				if (!tick.sda_in) begin
					scl_d   = 1'b0;
					phase_d = i2cbs_pkg::PH_IDLE;
					done    = 1'b1;
				end else if (poll_inc > {1'b0, ack_timeout}) begin
					// No acknowledge in time: fall into a stop sequence.
					poll_d  = '0;
					drive_d = 1'b1;
					scl_d   = 1'b0;
					phase_d = i2cbs_pkg::PH_ESTOP2;
				end else begin
					poll_d = poll_inc[7:0];
				end
			end
			i2cbs_pkg::PH_ESTOP2: begin
				sda_d   = 1'b0;
				phase_d = i2cbs_pkg::PH_ESTOP3;
			end
			i2cbs_pkg::PH_ESTOP3: begin
				scl_d   = 1'b1;
				phase_d = i2cbs_pkg::PH_ESTOP4;
			end
			i2cbs_pkg::PH_ESTOP4: begin
				sda_d   = 1'b1;
				phase_d = i2cbs_pkg::PH_IDLE;
				done    = 1'b1;
				err     = 1'b1;
			end
			i2cbs_pkg::PH_RBIT_A: begin
				scl_d   = 1'b1;
				phase_d = i2cbs_pkg::PH_RBIT_B;
			end
			i2cbs_pkg::PH_RBIT_B: begin
				shift_d     = {shift_q[i2cbs_pkg::BYTE_BITS-2:0], tick.sda_in};
				scl_d       = 1'b0;
				bit_count_d = bit_count_q + 4'd1;
				phase_d     = (bit_count_d >= 4'(i2cbs_pkg::BYTE_BITS)) ?
					i2cbs_pkg::PH_RACK_A : i2cbs_pkg::PH_RBIT_A;
			end
			i2cbs_pkg::PH_RACK_A: begin
				drive_d = 1'b1;
				sda_d   = !send_ack_q;
				scl_d   = 1'b0;
				phase_d = i2cbs_pkg::PH_RACK_B;
			end
			i2cbs_pkg::PH_RACK_B: begin
				scl_d   = 1'b1;
				phase_d = i2cbs_pkg::PH_RACK_C;
			end
			i2cbs_pkg::PH_RACK_C: begin
				scl_d     = 1'b0;
				rx_byte_d = shift_q;
				phase_d   = i2cbs_pkg::PH_IDLE;
				done      = 1'b1;
			end
			default: begin
				phase_d = i2cbs_pkg::PH_IDLE;
			end
		endcase
	end

	always_comb begin
		res.scl       = scl_d;
		res.sda_out   = sda_d;
		res.sda_drive = drive_d;
		res.busy_res  = (phase_d != i2cbs_pkg::PH_IDLE);
		res.done_res  = done;
		res.ack_error = err;
		res.read_data = rx_byte_d;
	end

endmodule
